// ===== hw/rtl/tcgr_pkg.sv =====
`timescale 1ns / 1ps

package tcgr_pkg;

  localparam int GlyphCountDef   = 256;
  localparam int MaxGlyphRowsDef = 32;
  localparam int GlyphWidth      = 8;

  localparam logic [7:0] NewlineCode = 8'd10;
  localparam logic [8:0] ColsLimit   = 9'd256;
  localparam logic [7:0] RowsLimit   = 8'd128;

  localparam logic [8:0] ColsReset   = 9'd80;
  localparam logic [7:0] RowsReset   = 8'd30;
  localparam logic [5:0] HeightReset = 6'd16;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_NEWLINE,
    CMD_DRAW
  } cmd_kind_e;

  typedef enum logic [1:0] {
    REG_TEXT_COLUMNS,
    REG_TEXT_ROWS,
    REG_GLYPH_HEIGHT
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_DRAW
  } back_state_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  glyph;
    logic [4:0]  row;
    logic [7:0]  font;
  } cmd_t;

  typedef struct packed {
    logic [8:0] cols;
    logic [7:0] rows;
    logic [5:0] height;
  } cfg_t;

  typedef struct packed {
    logic        last;
    logic [7:0]  mask;
    logic [11:0] y;
    logic [10:0] x;
  } out_t;

  // Remainder of a glyph row by the row count, for counts of seven or more.
  function automatic logic [4:0] row_mod(logic [4:0] row, logic [5:0] m);
    logic [5:0] v;
    v = {1'b0, row};
    for (int i = 0; i < 4; i++) begin
      if (v >= m) begin
        v = v - m;
      end
    end
    return v[4:0];
  endfunction

endpackage

// ===== hw/rtl/tcgr_front.sv =====
`timescale 1ns / 1ps

module tcgr_front #(
  parameter int GLYPH_COUNT    = 256,
  parameter int MAX_GLYPH_ROWS = 32
) (
  input  logic          action_i,
  input  logic [7:0]    char_code_i,
  input  logic [4:0]    glyph_row_i,
  input  logic [7:0]    font_byte_i,
  output tcgr_pkg::cmd_t cmd_o
);
  import tcgr_pkg::*;

  logic [8:0] code_ext;

  assign code_ext = {1'b0, char_code_i};

  always_comb begin
    cmd_o = '0;
    if (!action_i) begin
      cmd_o.kind = CMD_LOAD;
    end else if (char_code_i == NewlineCode) begin
      cmd_o.kind = CMD_NEWLINE;
    end else begin
      cmd_o.kind = CMD_DRAW;
    end
    if (code_ext >= 9'(GLYPH_COUNT)) begin
      cmd_o.glyph = 8'(code_ext - 9'(GLYPH_COUNT));
    end else begin
      cmd_o.glyph = char_code_i;
    end
    cmd_o.row  = row_mod(glyph_row_i, 6'(MAX_GLYPH_ROWS));
    cmd_o.font = font_byte_i;
  end

endmodule

// ===== hw/rtl/tcgr_cmd_fifo.sv =====
`timescale 1ns / 1ps

module tcgr_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcgr_pkg::cmd_t push_cmd_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tcgr_pkg::cmd_t pop_cmd_o
);
  import tcgr_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign ready_o   = (cnt_q != 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign pop_cmd_o = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d  = ~wr_q;
      cnt_d = cnt_d + 2'd1;
    end
    if (pop_i) begin
      rd_d  = ~rd_q;
      cnt_d = cnt_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hw/rtl/tcgr_back.sv =====
`timescale 1ns / 1ps

module tcgr_back #(
  parameter int GLYPH_COUNT    = 256,
  parameter int MAX_GLYPH_ROWS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcgr_pkg::cfg_t cfg_i,
  input  logic           cmd_valid_i,
  input  tcgr_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tcgr_pkg::out_t out_o
);
  import tcgr_pkg::*;

  localparam int Depth = GLYPH_COUNT * MAX_GLYPH_ROWS;
  localparam int AW    = $clog2(Depth);

  logic [7:0]  mem [Depth];

  back_state_e state_q, state_d;
  logic [4:0]  r_q, r_d;
  logic [7:0]  glyph_q, glyph_d;
  logic [10:0] sx_q, sx_d;
  logic [11:0] sy_q, sy_d;
  logic [7:0]  col_q, col_d;
  logic [6:0]  line_q, line_d;

  logic        inflight_q;
  logic [7:0]  rdata_q;
  logic [10:0] meta_x_q;
  logic [11:0] meta_y_q;
  logic        meta_last_q;

  out_t        buf_q [2];
  logic        owr_q, ord_q;
  logic [1:0]  occ_q, occ_d;

  logic [8:0]  cols_sat;
  logic [7:0]  rows_sat;
  logic [5:0]  height_sat;
  logic [8:0]  col_next;
  logic [7:0]  line_next;
  logic [12:0] sy_full;
  logic        out_pop;
  logic        issue;
  logic        last_now;
  logic [AW-1:0] raddr, waddr;

  assign cols_sat   = (cfg_i.cols > ColsLimit) ? ColsLimit : cfg_i.cols;
  assign rows_sat   = (cfg_i.rows > RowsLimit) ? RowsLimit : cfg_i.rows;
  assign height_sat = (cfg_i.height > 6'(MAX_GLYPH_ROWS)) ? 6'(MAX_GLYPH_ROWS) : cfg_i.height;
  assign sy_full    = 13'(line_q) * 13'(height_sat);

  assign out_pop     = out_valid_o && out_ready_i;
  assign out_valid_o = (occ_q != 2'd0);
  assign out_o       = buf_q[ord_q];

  assign last_now = ({1'b0, r_q} + 6'd1 == height_sat);
  assign issue    = (state_q == ST_DRAW) &&
                    ((3'(occ_q) + 3'(inflight_q)) <= (3'd1 + 3'(out_pop)));
  assign raddr    = AW'(32'(glyph_q) * MAX_GLYPH_ROWS + 32'(r_q));
  assign waddr    = AW'(32'(cmd_i.glyph) * MAX_GLYPH_ROWS + 32'(cmd_i.row));

  always_comb begin
    col_next  = 9'd0;
    line_next = {1'b0, line_q};
    if (cmd_i.kind == CMD_NEWLINE) begin
      line_next = line_next + 8'd1;
    end else begin
      col_next = {1'b0, col_q} + 9'd1;
    end
    if (col_next >= cols_sat) begin
      col_next  = 9'd0;
      line_next = line_next + 8'd1;
    end
    if (line_next >= rows_sat) begin
      line_next = 8'd0;
    end
  end

  always_comb begin
    state_d   = state_q;
    r_d       = r_q;
    glyph_d   = glyph_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    col_d     = col_q;
    line_d    = line_q;
    cmd_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_NEWLINE, CMD_DRAW: begin
              col_d  = col_next[7:0];
              line_d = line_next[6:0];
              if (cmd_i.kind == CMD_DRAW && height_sat != 6'd0) begin
                state_d = ST_DRAW;
                r_d     = 5'd0;
                glyph_d = cmd_i.glyph;
                sx_d    = 11'(col_q) * 11'(GlyphWidth);
                sy_d    = sy_full[11:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAW: begin
        if (issue) begin
          r_d = r_q + 5'd1;
          if (last_now) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    occ_d = occ_q;
    if (inflight_q) begin
      occ_d = occ_d + 2'd1;
    end
    if (out_pop) begin
      occ_d = occ_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      r_q        <= 5'd0;
      col_q      <= 8'd0;
      line_q     <= 7'd0;
      inflight_q <= 1'b0;
      owr_q      <= 1'b0;
      ord_q      <= 1'b0;
      occ_q      <= 2'd0;
    end else begin
      state_q    <= state_d;
      r_q        <= r_d;
      col_q      <= col_d;
      line_q     <= line_d;
      inflight_q <= issue;
      occ_q      <= occ_d;
      if (inflight_q) begin
        owr_q <= ~owr_q;
      end
      if (out_pop) begin
        ord_q <= ~ord_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q <= glyph_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    if (issue) begin
      meta_x_q    <= sx_q;
      meta_y_q    <= sy_q + 12'(r_q);
      meta_last_q <= last_now;
    end
    if (inflight_q) begin
      buf_q[owr_q] <= '{last: meta_last_q, mask: rdata_q, y: meta_y_q, x: meta_x_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.kind == CMD_LOAD) begin
      mem[waddr] <= cmd_i.font;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rdata_q <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/text_console_glyph_renderer_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// s_axis    in         tvalid / tready         tdata: char_code, glyph_row, font_byte; tuser
// m_axis    out        tvalid / tready         tdata: pixel_x, pixel_y, pixel_mask; tlast
// cfg       in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// A load or newline item is handled in the idle state of the back end; a drawn character
// then reads its glyph rows one at a time in the draw state, through the single read port of the glyph store.
// Reset clears the cursor and the queues; the glyph store holds no defined data until loaded.
// A two-entry command queue and a two-entry result buffer let input and output stall apart.
module text_console_glyph_renderer_core #(
  parameter int GLYPH_COUNT    = tcgr_pkg::GlyphCountDef,
  parameter int MAX_GLYPH_ROWS = tcgr_pkg::MaxGlyphRowsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_code [7:0], glyph_row [12:8], font_byte [20:13]
  input  logic [23:0] s_axis_tdata,
  // action
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_x [10:0], pixel_y [22:11], pixel_mask [30:23]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i
);
  import tcgr_pkg::*;

  cfg_t cfg_q;
  cmd_t front_cmd, queue_cmd;
  out_t out_item;
  logic queue_valid, queue_pop, push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cols   <= ColsReset;
      cfg_q.rows   <= RowsReset;
      cfg_q.height <= HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_TEXT_COLUMNS: cfg_q.cols   <= cfg_data_i;
        REG_TEXT_ROWS:    cfg_q.rows   <= cfg_data_i[7:0];
        REG_GLYPH_HEIGHT: cfg_q.height <= cfg_data_i[5:0];
        default: begin
        end
      endcase
    end
  end

  assign push = s_axis_tvalid && s_axis_tready;

  tcgr_front #(
    .GLYPH_COUNT   (GLYPH_COUNT),
    .MAX_GLYPH_ROWS(MAX_GLYPH_ROWS)
  ) u_front (
    .action_i   (s_axis_tuser),
    .char_code_i(s_axis_tdata[7:0]),
    .glyph_row_i(s_axis_tdata[12:8]),
    .font_byte_i(s_axis_tdata[20:13]),
    .cmd_o      (front_cmd)
  );

  tcgr_cmd_fifo u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(front_cmd),
    .ready_o   (s_axis_tready),
    .pop_i     (queue_pop),
    .valid_o   (queue_valid),
    .pop_cmd_o (queue_cmd)
  );

  tcgr_back #(
    .GLYPH_COUNT   (GLYPH_COUNT),
    .MAX_GLYPH_ROWS(MAX_GLYPH_ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(queue_valid),
    .cmd_i      (queue_cmd),
    .cmd_pop_o  (queue_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (out_item)
  );

  assign m_axis_tdata = {1'b0, out_item.mask, out_item.y, out_item.x};
  assign m_axis_tlast = out_item.last;

`ifndef SYNTH
  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_pop |-> queue_valid)
    else $error("command popped from an empty queue");

  a_stall_means_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> queue_valid)
    else $error("input stalled with no queued command");

  a_pop_then_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (queue_pop && !push) |=> s_axis_tready)
    else $error("queue still full after a pop");
`endif

endmodule

// ===== tb/sv/text_console_glyph_renderer_core_tb.sv =====
`timescale 1ns / 1ps

module text_console_glyph_renderer_core_tb;
  import tcgr_pkg::*;

  localparam logic ActLoad = 1'b0;
  localparam logic ActPut  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] code;
    logic [4:0] row;
    logic [7:0] font;
  } glyph_cmd_t;

  typedef struct packed {
    logic [10:0] x;
    logic [11:0] y;
    logic [7:0]  mask;
    logic        last;
  } pixel_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [8:0]  cfg_data_i;

  glyph_cmd_t pending_cmds[$];
  pixel_row_t pixel_rows_due[$];

  logic [7:0] glyph_bytes[0:8191];
  logic       row_loaded[0:8191];
  logic [8:0] reg_cols;
  logic [7:0] reg_rows;
  logic [5:0] reg_height;
  int         cur_col;
  int         cur_line;

  int   fail_count;
  logic in_taken;
  logic steady;

  text_console_glyph_renderer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch in %s: expected 'h%0h, got 'h%0h", what, want, got);
    end
  endtask

  task automatic render_char(input glyph_cmd_t c);
    int cols;
    int rows;
    int height;
    int col;
    int line;
    pixel_row_t r;
    cols   = (reg_cols > 256) ? 256 : int'(reg_cols);
    rows   = (reg_rows > 128) ? 128 : int'(reg_rows);
    height = (reg_height > 32) ? 32 : int'(reg_height);
    col    = cur_col;
    line   = cur_line;
    if (c.action == ActLoad) begin
      glyph_bytes[{c.code, c.row}] = c.font;
    end else begin
      if (c.code == NewlineCode) begin
        col = 0;
        line++;
      end else begin
        for (int rr = 0; rr < height; rr++) begin
          r.x    = 11'(col * GlyphWidth);
          r.y    = 12'(line * height + rr);
          r.mask = glyph_bytes[{c.code, 5'(rr)}];
          r.last = (rr == height - 1);
          pixel_rows_due.push_back(r);
        end
        col++;
      end
      if (col >= cols) begin
        col = 0;
        line++;
      end
      if (line >= rows) begin
        line = 0;
      end
      cur_col  = col & 255;
      cur_line = line & 127;
    end
  endtask

  always @(posedge clk_i) begin : watch_input
    glyph_cmd_t c;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      c.action = s_axis_tuser;
      c.code   = s_axis_tdata[7:0];
      c.row    = s_axis_tdata[12:8];
      c.font   = s_axis_tdata[20:13];
      render_char(c);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin : drive_input
    logic hold;
    glyph_cmd_t c;
    hold = s_axis_tvalid && !in_taken;
    if (in_taken) begin
      void'(pending_cmds.pop_front());
      in_taken = 1'b0;
    end
    if (!hold) begin
      if (rst_ni && pending_cmds.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
        c = pending_cmds[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, c.font, c.row, c.code};
        s_axis_tuser  <= c.action;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && (steady || $urandom_range(99) >= 31);
  end

  always @(posedge clk_i) begin : watch_pixels
    pixel_row_t got;
    pixel_row_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x    = m_axis_tdata[10:0];
      got.y    = m_axis_tdata[22:11];
      got.mask = m_axis_tdata[30:23];
      got.last = m_axis_tlast;
      if (pixel_rows_due.size() == 0) begin
        note_mismatch("unexpected pixel row", 0, m_axis_tdata);
      end else begin
        want = pixel_rows_due.pop_front();
        if (got.x != want.x) note_mismatch("pixel_x", want.x, got.x);
        if (got.y != want.y) note_mismatch("pixel_y", want.y, got.y);
        if (got.mask != want.mask) note_mismatch("pixel_mask", want.mask, got.mask);
        if (got.last != want.last) note_mismatch("last_row", want.last, got.last);
      end
    end
  end

  task automatic load_row(input logic [7:0] code, input logic [4:0] row,
                          input logic [7:0] font);
    glyph_cmd_t c;
    c.action = ActLoad;
    c.code   = code;
    c.row    = row;
    c.font   = font;
    pending_cmds.push_back(c);
    row_loaded[{code, row}] = 1'b1;
  endtask

  // Rows of the glyph that the current height reads are loaded first, so
  // that no draw ever touches a store entry that was never written.
  task automatic put_char(input logic [7:0] code);
    glyph_cmd_t c;
    int height;
    height = (reg_height > 32) ? 32 : int'(reg_height);
    if (code != NewlineCode) begin
      for (int r = 0; r < height; r++) begin
        if (!row_loaded[{code, 5'(r)}]) begin
          load_row(code, 5'(r), 8'($urandom_range(255)));
        end
      end
    end
    c.action = ActPut;
    c.code   = code;
    c.row    = 5'($urandom_range(31));
    c.font   = 8'($urandom_range(255));
    pending_cmds.push_back(c);
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || pixel_rows_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_reg(input cfg_reg_e idx, input logic [8:0] val);
    drain();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_TEXT_COLUMNS: begin
        reg_cols = val;
      end
      REG_TEXT_ROWS: begin
        reg_rows = val[7:0];
      end
      default: begin
        reg_height = val[5:0];
      end
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int pick;
    logic [7:0] pool[2];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    fail_count    = 0;
    in_taken      = 1'b0;
    steady        = 1'b0;
    reg_cols      = ColsReset;
    reg_rows      = RowsReset;
    reg_height    = HeightReset;
    cur_col       = 0;
    cur_line      = 0;
    for (int i = 0; i < 8192; i++) begin
      glyph_bytes[i] = 8'h00;
      row_loaded[i]  = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration, extreme codes and font bytes.
    load_row(8'd0, 5'd0, 8'h00);
    load_row(8'd0, 5'd1, 8'hFF);
    load_row(8'd255, 5'd0, 8'hFF);
    load_row(8'd255, 5'd1, 8'h00);
    put_char(8'd0);
    put_char(NewlineCode);
    put_char(8'd0);

    // One column and one line: every character wraps back to the origin.
    set_reg(REG_TEXT_COLUMNS, 9'd1);
    set_reg(REG_TEXT_ROWS, 9'd1);
    set_reg(REG_GLYPH_HEIGHT, 9'd1);
    put_char(8'd65);
    put_char(8'd0);
    put_char(NewlineCode);
    put_char(8'd255);

    // Zero limits: no rows drawn while the height is zero, every move wraps and the line stays at zero.
    set_reg(REG_TEXT_COLUMNS, 9'd0);
    set_reg(REG_TEXT_ROWS, 9'd0);
    set_reg(REG_GLYPH_HEIGHT, 9'd0);
    put_char(8'd65);
    put_char(8'd200);
    put_char(NewlineCode);
    set_reg(REG_GLYPH_HEIGHT, 9'd3);
    put_char(8'd65);
    put_char(NewlineCode);
    put_char(8'd255);

    // Register values above their ranges saturate.
    set_reg(REG_TEXT_COLUMNS, 9'd511);
    set_reg(REG_TEXT_ROWS, 9'd255);
    set_reg(REG_GLYPH_HEIGHT, 9'd63);
    put_char(NewlineCode);
    put_char(NewlineCode);
    put_char(8'd0);
    put_char(8'd0);

    // The cursor is left beyond limits that then shrink.
    set_reg(REG_TEXT_COLUMNS, 9'd200);
    set_reg(REG_TEXT_ROWS, 9'd100);
    set_reg(REG_GLYPH_HEIGHT, 9'd2);
    for (int i = 0; i < 5; i++) put_char(NewlineCode);
    for (int i = 0; i < 12; i++) put_char(8'd97 + 8'(i % 3));
    set_reg(REG_TEXT_COLUMNS, 9'd3);
    set_reg(REG_TEXT_ROWS, 9'd2);
    put_char(8'd97);
    put_char(8'd98);
    put_char(8'd99);

    for (int ph = 0; ph < 4; ph++) begin
      set_reg(REG_TEXT_COLUMNS, 9'($urandom_range(1, 12)));
      set_reg(REG_TEXT_ROWS, 9'($urandom_range(1, 6)));
      set_reg(REG_GLYPH_HEIGHT,
              (ph == 3) ? 9'($urandom_range(17, 32)) : 9'($urandom_range(1, 8)));
      steady = (ph == 1);
      for (int k = 0; k < 2; k++) pool[k] = (ph == 3) ? 8'd0 : 8'($urandom_range(255));
      for (int n = 0; n < 6; n++) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          load_row(8'($urandom_range(255)), 5'($urandom_range(31)),
                   8'($urandom_range(255)));
        end else if (pick < 25) begin
          put_char(NewlineCode);
        end else begin
          put_char(pool[$urandom_range(1)]);
        end
      end
    end
    drain();
    steady = 1'b0;

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tcgr_pkg.sv
hw/rtl/tcgr_front.sv
hw/rtl/tcgr_cmd_fifo.sv
hw/rtl/tcgr_back.sv
hw/rtl/text_console_glyph_renderer_core.sv
tb/sv/text_console_glyph_renderer_core_tb.sv
